@@ sv/rlf_pkg.sv @@
// Shared types, constants and rounding helpers for the RMS level follower.
package rlf_pkg;

  // Shared multiplier operand and product widths.
  localparam int unsigned MAC_A_W = 19;
  localparam int unsigned MAC_B_W = 18;
  localparam int unsigned PROD_W  = MAC_A_W + MAC_B_W;
  localparam int unsigned ACC_W   = 56;
  localparam int unsigned RND_W   = ACC_W - 16;

  // Datapath widths.
  localparam int unsigned SMP_W = 16;
  localparam int unsigned FRQ_W = 16;
  localparam int unsigned T_W   = 18;
  localparam int unsigned P_W   = 18;
  localparam int unsigned OMP_W = 19;
  localparam int unsigned SQ_W  = 31;
  localparam int unsigned MS_W  = 36;
  localparam int unsigned LVL_W = 15;
  localparam int unsigned RAD_W = 30;

  // Tangent polynomial coefficients in Q0.16.
  localparam logic signed [T_W-1:0] POLY_C3 = 18'sd63156;
  localparam logic signed [T_W-1:0] POLY_C2 = 18'sd56699;
  localparam logic signed [T_W-1:0] POLY_C1 = 18'sd35112;
  localparam logic signed [T_W-1:0] POLY_C0 = 18'sd60948;

  localparam logic signed [P_W-1:0]   P_MAX   = 18'sd131071;
  localparam logic signed [P_W-1:0]   P_MIN   = -18'sd131072;
  localparam logic signed [MS_W-1:0]  MS_MAX  = {1'b0, {(MS_W-1){1'b1}}};
  localparam logic signed [MS_W-1:0]  MS_MIN  = {1'b1, {(MS_W-1){1'b0}}};
  localparam logic [LVL_W-1:0]        LVL_MAX = {LVL_W{1'b1}};

  // Left shift applied to a product before it enters the accumulator.
  typedef enum logic [1:0] {
    SH_0,
    SH_2,
    SH_17,
    SH_19
  } acc_sh_e;

  // Control word from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic    mul_en;
    logic    acc_en;
    logic    acc_clr;
    acc_sh_e sh;
  } mac_ctrl_t;

  // Constant added after each Horner product, by step.
  function automatic logic signed [T_W-1:0] horner_add(input logic [1:0] step);
    case (step)
      2'd0:    return -POLY_C2;
      2'd1:    return POLY_C1;
      2'd2:    return POLY_C0;
      default: return '0;
    endcase
  endfunction

  // Divide by 2^16, rounding to nearest with halves away from zero.
  function automatic logic signed [RND_W-1:0] rnd16(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] biased;
    biased = v[ACC_W-1] ? (v + ACC_W'(32767)) : (v + ACC_W'(32768));
    return biased[ACC_W-1:16];
  endfunction

endpackage

@@ sv/rlf_mac.sv @@
// Shared signed multiplier with a registered product and a shifting accumulator.
module rlf_mac (
  input  logic                                 clk_i,
  input  rlf_pkg::mac_ctrl_t                   ctrl_i,
  input  logic signed [rlf_pkg::MAC_A_W-1:0]   a_i,
  input  logic signed [rlf_pkg::MAC_B_W-1:0]   b_i,
  output logic signed [rlf_pkg::PROD_W-1:0]    prod_o,
  output logic signed [rlf_pkg::ACC_W-1:0]     acc_o
);
  import rlf_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  base;

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign base     = ctrl_i.acc_clr ? '0 : acc_q;

  always_comb begin
    case (ctrl_i.sh)
      SH_0:    addend = prod_ext;
      SH_2:    addend = prod_ext <<< 2;
      SH_17:   addend = prod_ext <<< 17;
      SH_19:   addend = prod_ext <<< 19;
      default: addend = prod_ext;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= base + addend;
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

@@ sv/rlf_sqrt.sv @@
// Restoring integer square root, one result bit per cycle.
module rlf_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rlf_pkg::RAD_W-1:0]    rad_i,
  output logic                         done_o,
  output logic [rlf_pkg::LVL_W-1:0]    root_o
);
  import rlf_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [3:0]         cnt_q;
  logic [RAD_W-1:0]   rad_q;
  logic [LVL_W:0]     rem_q;
  logic [LVL_W-1:0]   root_q;

  logic [LVL_W+2:0]   rem_sh;
  logic [LVL_W+2:0]   trial;
  logic [LVL_W+2:0]   diff;
  logic               fits;

  // The remainder never exceeds twice the partial root, so it fits LVL_W+1 bits.
  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign diff   = rem_sh - trial;
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'(LVL_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= fits ? diff[LVL_W:0] : rem_sh[LVL_W:0];
      root_q <= {root_q[LVL_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ sv/rms_level_follower_core.sv @@
// Top level of the RMS level follower: sequencer around a shared multiplier and a square root.
//
//   channel | direction | valid       | stall        | payload
//   --------+-----------+-------------+--------------+---------------------------
//   in      | input     | in_valid_i  | in_stall_o   | sample_i, norm_freq_i
//   out     | output    | out_valid_o | out_stall_i  | rms_level_o
//
// The square root runs only when the mean square is positive and below one; the
// next item is taken in the cycle after the result is loaded. The time an item
// takes is set by the one multiplier, which is used nine times per item, and by
// the square root, which finds one bit per cycle. Reset clears the mean square to
// zero and empties the output register. A result waiting under out_stall_i does
// not block the next item; only the hand-over of a newer result waits until the
// older one has been taken.
module rms_level_follower_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [rlf_pkg::SMP_W-1:0]    sample_i,
  input  logic [rlf_pkg::FRQ_W-1:0]           norm_freq_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rlf_pkg::LVL_W-1:0]           rms_level_o
);
  import rlf_pkg::*;

  // The sequencer walks through the Horner steps, the coefficient, the square of
  // the sample, the four partial products of the update and the square root.
  typedef enum logic [3:0] {
    S_IDLE,
    S_HORN_MUL,
    S_HORN_ADD,
    S_COEF,
    S_SQ_MUL,
    S_SQ_LD,
    S_T0_MUL,
    S_T1_MUL,
    S_T2_MUL,
    S_T3_MUL,
    S_T3_ACC,
    S_ROUND,
    S_SQRT_START,
    S_SQRT_WAIT,
    S_OUT
  } state_e;

  state_e                    state_q;
  logic [1:0]                hstep_q;
  logic                      out_valid_q;
  logic [LVL_W-1:0]          rms_level_q;
  logic signed [MS_W-1:0]    m_q;

  logic signed [SMP_W-1:0]   s_q;
  logic [FRQ_W-1:0]          f_q;
  logic signed [T_W-1:0]     t_q;
  logic signed [P_W-1:0]     p_q;
  logic signed [OMP_W-1:0]   omp_q;
  logic [SQ_W-1:0]           sq_q;
  logic [LVL_W-1:0]          level_q;

  mac_ctrl_t                 mac_ctrl;
  logic signed [MAC_A_W-1:0] mac_a;
  logic signed [MAC_B_W-1:0] mac_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic                      accept;
  logic signed [RND_W-1:0]   horn_rnd;
  logic signed [T_W-1:0]     t_d;
  logic signed [P_W+1:0]     p_wide;
  logic signed [P_W-1:0]     p_d;
  logic signed [OMP_W-1:0]   omp_d;
  logic signed [RND_W-1:0]   ms_rnd;
  logic signed [MS_W-1:0]    m_d;
  logic                      ms_nonpos;
  logic                      ms_big;
  logic                      sqrt_start;
  logic                      sqrt_done;
  logic [LVL_W-1:0]          sqrt_root;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // Horner step: round the product with f back to Q.16 and add the next constant.
  assign horn_rnd = rnd16({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});
  assign t_d      = horn_rnd[T_W-1:0] + horner_add(hstep_q);

  // Coefficient p = 1 - 2*poly, saturated; the polynomial is never negative here.
  assign p_wide = 20'sd65536 - {{1{t_q[T_W-1]}}, t_q, 1'b0};
  always_comb begin
    if (p_wide < 20'(P_MIN)) begin
      p_d = P_MIN;
    end else if (p_wide > 20'(P_MAX)) begin
      p_d = P_MAX;
    end else begin
      p_d = p_wide[P_W-1:0];
    end
  end
  assign omp_d = 19'sd65536 - {p_d[P_W-1], p_d};

  // Rounded update, saturated into the mean square range.
  assign ms_rnd = rnd16(acc);
  always_comb begin
    if (ms_rnd[RND_W-1:MS_W-1] == '0 || ms_rnd[RND_W-1:MS_W-1] == '1) begin
      m_d = ms_rnd[MS_W-1:0];
    end else if (ms_rnd[RND_W-1]) begin
      m_d = MS_MIN;
    end else begin
      m_d = MS_MAX;
    end
  end

  // A level of zero stands for a mean square that is zero or negative; a mean
  // square of one or more gives full scale without running the root.
  assign ms_nonpos  = m_q[MS_W-1] || (m_q == '0);
  assign ms_big     = (m_q[MS_W-2:RAD_W+2] != '0);
  assign sqrt_start = (state_q == S_SQRT_START) && !ms_nonpos && !ms_big;

  // Operand selection for the shared multiplier. The update is split into
  // (1-p) times the low and high halves of s*s, and p times the high and low
  // halves of the mean square, each product accumulated one step later.
  always_comb begin
    mac_ctrl = '0;
    mac_a    = '0;
    mac_b    = '0;
    case (state_q)
      S_HORN_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        mac_a           = {t_q[T_W-1], t_q};
        mac_b           = {2'b00, f_q};
      end
      S_SQ_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        mac_a           = {{(MAC_A_W-SMP_W){s_q[SMP_W-1]}}, s_q};
        mac_b           = {{(MAC_B_W-SMP_W){s_q[SMP_W-1]}}, s_q};
      end
      S_T0_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        mac_a           = omp_q;
        mac_b           = {1'b0, sq_q[16:0]};
      end
      S_T1_MUL: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.acc_en  = 1'b1;
        mac_ctrl.acc_clr = 1'b1;
        mac_ctrl.sh      = SH_2;
        mac_a            = omp_q;
        mac_b            = {4'b0000, sq_q[SQ_W-1:17]};
      end
      S_T2_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_en = 1'b1;
        mac_ctrl.sh     = SH_19;
        mac_a           = m_q[MS_W-1:17];
        mac_b           = p_q;
      end
      S_T3_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_en = 1'b1;
        mac_ctrl.sh     = SH_17;
        mac_a           = {2'b00, m_q[16:0]};
        mac_b           = p_q;
      end
      S_T3_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        mac_ctrl.sh     = SH_0;
      end
      default: ;
    endcase
  end

  rlf_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  rlf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (m_q[RAD_W+1:2]),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // Sequencer state, the kept mean square and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hstep_q     <= '0;
      out_valid_q <= 1'b0;
      rms_level_q <= '0;
      m_q         <= '0;
    end else begin
      // In S_OUT the hand-over below decides the output valid on its own.
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            hstep_q <= '0;
            state_q <= S_HORN_MUL;
          end
        end
        S_HORN_MUL: state_q <= S_HORN_ADD;
        S_HORN_ADD: begin
          hstep_q <= hstep_q + 2'd1;
          state_q <= (hstep_q == 2'd3) ? S_COEF : S_HORN_MUL;
        end
        S_COEF:   state_q <= S_SQ_MUL;
        S_SQ_MUL: state_q <= S_SQ_LD;
        S_SQ_LD:  state_q <= S_T0_MUL;
        S_T0_MUL: state_q <= S_T1_MUL;
        S_T1_MUL: state_q <= S_T2_MUL;
        S_T2_MUL: state_q <= S_T3_MUL;
        S_T3_MUL: state_q <= S_T3_ACC;
        S_T3_ACC: state_q <= S_ROUND;
        S_ROUND: begin
          m_q     <= m_d;
          state_q <= S_SQRT_START;
        end
        S_SQRT_START: state_q <= sqrt_start ? S_SQRT_WAIT : S_OUT;
        S_SQRT_WAIT: begin
          if (sqrt_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            rms_level_q <= level_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          s_q <= sample_i;
          f_q <= norm_freq_i;
          t_q <= POLY_C3;
        end
      end
      S_HORN_ADD: t_q <= t_d;
      S_COEF: begin
        p_q   <= p_d;
        omp_q <= omp_d;
      end
      S_SQ_LD: sq_q <= prod[SQ_W-1:0];
      S_SQRT_START: begin
        if (ms_nonpos) begin
          level_q <= '0;
        end else if (ms_big) begin
          level_q <= LVL_MAX;
        end
      end
      S_SQRT_WAIT: begin
        if (sqrt_done) begin
          level_q <= sqrt_root;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign rms_level_o = rms_level_q;

endmodule

@@ sv/rlf_checker.sv @@
// Port-level checks for the RMS level follower, bound to its top level.
module rlf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [rlf_pkg::LVL_W-1:0]    rms_level_o
);

  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block took no time for an accepted item");

  // A new result is handed over only as the sequencer returns to idle.
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result appeared while the block was still busy");

  a_out_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result was dropped");

  a_out_level_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(rms_level_o))
    else $error("stalled result changed");

endmodule

bind rms_level_follower_core rlf_checker u_rlf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .rms_level_o (rms_level_o)
);

@@ verif/tb.sv @@
// Self-checking testbench for the RMS level follower core.
`timescale 1ns / 1ps

module tb;

  // Fixed-point constants of the level follower, widened for exact integer math.
  localparam longint TAN_C3  = longint'(rlf_pkg::POLY_C3);
  localparam longint TAN_C2  = longint'(rlf_pkg::POLY_C2);
  localparam longint TAN_C1  = longint'(rlf_pkg::POLY_C1);
  localparam longint TAN_C0  = longint'(rlf_pkg::POLY_C0);
  localparam longint COEF_HI = longint'(rlf_pkg::P_MAX);
  localparam longint COEF_LO = longint'(rlf_pkg::P_MIN);
  localparam longint MSQ_HI  = longint'(rlf_pkg::MS_MAX);
  localparam longint MSQ_LO  = longint'(rlf_pkg::MS_MIN);
  localparam longint LVL_TOP = longint'(rlf_pkg::LVL_MAX);
  localparam longint UNITY   = 65536;

  // Cycles without any handshake before the run is declared hung. The limit
  // covers one item together with a sender gap and a receiver stall.
  localparam int STUCK_LIMIT = 2000;
  // Items left in the queue when idling on both sides is switched off.
  localparam int CALM_TAIL   = 80;

  typedef struct {
    logic signed [rlf_pkg::SMP_W-1:0] smp;
    logic [rlf_pkg::FRQ_W-1:0]        frq;
    bit                               drain;  // hold this item until all levels are back
  } audio_item_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [rlf_pkg::SMP_W-1:0]  sample;
  logic [rlf_pkg::FRQ_W-1:0]         norm_freq;
  logic                              out_valid;
  logic                              out_stall;
  logic [rlf_pkg::LVL_W-1:0]         rms_level;

  audio_item_t                 pending_items[$];
  logic [rlf_pkg::LVL_W-1:0]   level_q[$];
  longint                      mean_sq;
  int unsigned                 sent_cnt;
  int unsigned                 done_cnt;
  int unsigned                 errors;
  int unsigned                 stuck_cyc;
  bit                          calm;

  rms_level_follower_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .sample_i    (sample),
    .norm_freq_i (norm_freq),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .rms_level_o (rms_level)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Divide by 2^16 and round to nearest, halves away from zero.
  function automatic longint round_q16(input longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + 32768) >> 16;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint root_floor(input longint v);
    longint r;
    longint trial;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = r | (longint'(1) << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // Advances the smoothed mean square by one sample and returns the level that
  // the block must produce for it.
  function automatic logic [rlf_pkg::LVL_W-1:0] follow_level(
    input logic signed [rlf_pkg::SMP_W-1:0] smp,
    input logic [rlf_pkg::FRQ_W-1:0]        frq
  );
    longint s;
    longint f;
    longint t;
    longint p;
    longint m;
    longint r;
    s = smp;
    f = frq;
    // Horner evaluation of the tangent polynomial, rounding after each product.
    t = round_q16(TAN_C3 * f) - TAN_C2;
    t = round_q16(t * f) + TAN_C1;
    t = round_q16(t * f) + TAN_C0;
    t = round_q16(t * f);
    p = UNITY - 2 * t;
    if (p > COEF_HI) p = COEF_HI;
    if (p < COEF_LO) p = COEF_LO;
    // The sum is exact in Q.48; only the final step back to Q.32 rounds.
    m = round_q16((UNITY - p) * (s * s * 4) + p * mean_sq);
    if (m > MSQ_HI) m = MSQ_HI;
    if (m < MSQ_LO) m = MSQ_LO;
    mean_sq = m;
    // A mean square that is zero or negative flushes the level to zero.
    if (m <= 0) return '0;
    r = root_floor(m >> 2);
    if (r > LVL_TOP) r = LVL_TOP;
    return r[rlf_pkg::LVL_W-1:0];
  endfunction

  task automatic add_item(input int smp, input int frq, input bit drain);
    audio_item_t it;
    it.smp   = smp[rlf_pkg::SMP_W-1:0];
    it.frq   = frq[rlf_pkg::FRQ_W-1:0];
    it.drain = drain;
    pending_items.push_back(it);
  endtask

  // Sender. An item stays on the bus unchanged while it is stalled. After an
  // accepted item a random gap may follow; an item marked for draining waits
  // until every level sent so far has come back.
  always @(posedge clk or negedge rst_n) begin : drive
    int unsigned sent_now;
    logic        nxt_valid;
    int          nxt_gap;
    int          gap;
    audio_item_t it;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      sample    <= '0;
      norm_freq <= '0;
      sent_cnt  <= 0;
      calm      <= 1'b0;
      gap       = 0;
    end else begin
      sent_now  = sent_cnt + ((in_valid && !in_stall) ? 1 : 0);
      nxt_valid = in_valid;
      nxt_gap   = gap;
      if (in_valid && !in_stall) begin
        nxt_valid = 1'b0;
        // Gaps come in stretches of items; every third hundred runs back to back.
        if (!calm && ((sent_now / 100) % 3 != 0) && $urandom_range(0, 3) == 0)
          nxt_gap = $urandom_range(1, 9);
      end
      if (!nxt_valid) begin
        if (nxt_gap > 0) begin
          nxt_gap--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain && sent_now != done_cnt)) begin
          it = pending_items.pop_front();
          nxt_valid = 1'b1;
          sample    <= it.smp;
          norm_freq <= it.frq;
        end
      end
      gap = nxt_gap;
      in_valid <= nxt_valid;
      sent_cnt <= sent_now;
      calm     <= (pending_items.size() < CALM_TAIL);
    end
  end

  // Receiver stalls in bursts, with quiet phases in between and none at the end.
  always @(posedge clk or negedge rst_n) begin : backpressure
    int          burst;
    int unsigned cyc;
    if (!rst_n) begin
      out_stall <= 1'b0;
      burst     = 0;
      cyc       = 0;
    end else begin
      cyc++;
      if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!calm && ((cyc / 400) % 3 != 0) && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Checker. A returning level is compared before the prediction for an item
  // accepted at the same edge is queued, so the order within the step is fixed.
  always @(posedge clk or negedge rst_n) begin : check
    logic [rlf_pkg::LVL_W-1:0] want;
    if (!rst_n) begin
      mean_sq  = 0;
      done_cnt <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (level_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: level %0d with no item outstanding", $realtime, rms_level);
        end else begin
          want = level_q.pop_front();
          if (rms_level !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: rms_level expected %0d got %0d", $realtime, want, rms_level);
          end
        end
        done_cnt <= done_cnt + 1;
      end
      if (in_valid && !in_stall)
        level_q.push_back(follow_level(sample, norm_freq));
    end
  end

  // Watchdog on handshake activity.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        stuck_cyc <= 0;
      else
        stuck_cyc <= stuck_cyc + 1;
      if (stuck_cyc >= STUCK_LIMIT) begin
        $display("FAIL rms_level_follower_core");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int seg_len;
    int amp;
    int style;
    int seg_freq;
    int smp;
    int frq;
    int n;
    errors    = 0;
    stuck_cyc = 0;
    rst_n     = 1'b0;

    // Directed part: field extremes, a held level at zero frequency, and a run
    // at the top frequency where the coefficient pins at its lower bound, the
    // mean square overflows both ways, turns negative and the level saturates.
    add_item(0, 0, 1'b0);
    add_item(32767, 1000, 1'b0);
    add_item(-32768, 1000, 1'b0);
    add_item(1, 1000, 1'b0);
    add_item(-1, 32768, 1'b0);
    add_item(32767, 32768, 1'b0);
    add_item(-32768, 0, 1'b0);
    add_item(-32768, 65535, 1'b0);
    add_item(-32768, 65535, 1'b0);
    add_item(32767, 65535, 1'b0);
    add_item(-32768, 65535, 1'b0);
    add_item(0, 65535, 1'b0);
    add_item(0, 0, 1'b0);
    add_item(0, 40000, 1'b0);
    add_item(21845, 43690, 1'b0);
    add_item(-21846, 21845, 1'b0);
    add_item(16384, 16384, 1'b0);
    add_item(-16384, 1, 1'b0);
    add_item(32767, 32767, 1'b0);
    add_item(-32768, 32768, 1'b0);
    add_item(255, 255, 1'b0);
    add_item(-256, 65280, 1'b0);

    // Random part: segments of steady loudness and cutoff, as a real signal
    // would give, mixed with segments of fully random items.
    n = 0;
    while (n < 1000) begin
      seg_len  = $urandom_range(10, 60);
      amp      = $urandom_range(0, 9) < 3 ? $urandom_range(0, 2000) : $urandom_range(0, 32768);
      style    = $urandom_range(0, 9);
      seg_freq = $urandom_range(0, 9) < 7 ? $urandom_range(0, 4000) : $urandom_range(0, 65535);
      for (int i = 0; i < seg_len && n < 1000; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          smp = int'($urandom_range(0, 65535)) - 32768;
        end else begin
          smp = int'($urandom_range(0, 2 * amp)) - amp;
          if (smp > 32767) smp = 32767;
        end
        case (style)
          0, 1, 2, 3, 4: frq = $urandom_range(0, 2000);
          5, 6:          frq = $urandom_range(0, 32768);
          7:             frq = $urandom_range(0, 65535);
          default:       frq = seg_freq;
        endcase
        add_item(smp, frq, (n % 300) == 0);
        n++;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || level_q.size() != 0)
      @(posedge clk);
    // Room for any stray level the block might still send.
    repeat (60) @(posedge clk);

    if (errors == 0 && level_q.size() == 0) begin
      $display("PASS rms_level_follower_core");
    end else begin
      $display("FAIL rms_level_follower_core");
    end
    $finish;
  end

endmodule
